/* hdl/tlsb_pkg.sv */
// tlsb_pkg: shared types, codes, constants and helper functions for the
// turtle l-system segment builder; no dependencies
`default_nettype none

package tlsb_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned MAX_SEG_DEF     = 4096;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned ANG_W   = 16;
  localparam int unsigned STK_W   = 2 * POS_W + ANG_W;
  localparam int unsigned SEG_DW  = 4 * POS_W;
  localparam int unsigned MAG_W   = 34;
  localparam int unsigned DIV_NW  = 50;
  localparam int unsigned DIV_CW  = $clog2(DIV_NW);

  localparam logic [2:0]  SINE_LAT = 3'd4;
  localparam logic [15:0] QUARTER  = 16'd16384;

  localparam logic [1:0] REQ_CMD  = 2'd0;
  localparam logic [1:0] REQ_END  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MOVE  = 8'h62;
  localparam logic [7:0] CH_PUSH  = 8'h5B;
  localparam logic [7:0] CH_POP   = 8'h5D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [2:0] REG_TURN_STEP  = 3'd0;
  localparam logic [2:0] REG_START_HEAD = 3'd1;
  localparam logic [2:0] REG_GAMMA      = 3'd2;
  localparam logic [2:0] REG_DRAW_CHARS = 3'd3;
  localparam logic [2:0] REG_DRAW_COUNT = 3'd4;

  localparam int unsigned ERR_UNDERFLOW = 0;
  localparam int unsigned ERR_OVERFLOW  = 1;
  localparam int unsigned ERR_FULL      = 2;

  localparam logic [15:0] TURN_STEP_RST  = 16'd16384;
  localparam logic [15:0] START_HEAD_RST = 16'd16384;
  localparam logic [15:0] GAMMA_RST      = 16'd29491;
  localparam logic [63:0] DRAW_CHARS_RST = 64'd70;
  localparam logic [3:0]  DRAW_COUNT_RST = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_STEP,
    ST_POP_LOAD,
    ST_SEG_RD,
    ST_COORD,
    ST_DIV_WAIT,
    ST_RESULT
  } tlsb_state_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_MLO,
    DV_MHI,
    DV_RUN,
    DV_DONE
  } div_state_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [31:0]      den;
    logic [15:0]      gamma;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] quo;
  } div_rsp_t;

  function automatic logic is_draw(input logic [63:0] chars, input logic [3:0] cnt,
                                   input logic [7:0] ch);
    logic       hit;
    logic [3:0] n;
    hit = 1'b0;
    n   = (cnt > 4'd8) ? 4'd8 : cnt;
    for (int i = 0; i < 8; i++) begin
      if ((4'(i) < n) && (chars[8*i +: 8] == ch)) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic signed [31:0] sat_step(input logic signed [31:0] p,
                                                  input logic signed [15:0] v);
    logic signed [32:0] sum;
    sum = {p[31], p} + {{16{v[15]}}, v, 1'b0};
    if (sum[32] != sum[31]) begin
      return sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return sum[31:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/tlsb_ram.sv */
// tlsb_ram: single-port-write, single-port-read synchronous memory with
// registered read data; depends on nothing
`default_nettype none

module tlsb_ram #(
  parameter int unsigned WIDTH  = 80,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/tlsb_sine.sv */
// tlsb_sine: four-stage pipelined q1.15 sine of a 16-bit binary angle,
// polynomial per quarter; depends on tlsb_pkg
`default_nettype none

module tlsb_sine (
  input  wire logic                           clk,
  input  wire logic [tlsb_pkg::ANG_W-1:0]     angle,
  output logic signed [15:0]                  sine
);

  logic [1:0]  q_1, q_2, q_3;
  logic [14:0] z0, z_1, z_2, z_3;
  logic [29:0] zz;
  logic [14:0] z2_0, z2_1, z2_2;
  logic [26:0] m1;
  logic [14:0] a_1, a_2;
  logic [29:0] m2;
  logic [15:0] t_2, t_3;
  logic [30:0] m3;
  logic [16:0] s_3;
  logic [14:0] mag_3;
  logic signed [15:0] res_3;

  always_comb begin
    z0   = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    zz   = 30'(z0) * 30'(z0);
    z2_0 = zz[28:14];
  end

  always_ff @(posedge clk) begin
    z_1  <= z0;
    z2_1 <= z2_0;
    q_1  <= angle[15:14];
  end

  always_comb begin
    m1  = 27'(z2_1) * 27'd2320;
    a_1 = 15'd21024 - 15'(m1 >> 14);
  end

  always_ff @(posedge clk) begin
    a_2  <= a_1;
    z2_2 <= z2_1;
    z_2  <= z_1;
    q_2  <= q_1;
  end

  always_comb begin
    m2  = 30'(a_2) * 30'(z2_2);
    t_2 = 16'd51472 - 16'(m2 >> 14);
  end

  always_ff @(posedge clk) begin
    t_3 <= t_2;
    z_3 <= z_2;
    q_3 <= q_2;
  end

  always_comb begin
    m3    = 31'(t_3) * 31'(z_3);
    s_3   = m3[30:14];
    mag_3 = (s_3 > 17'd32767) ? 15'h7FFF : s_3[14:0];
    res_3 = q_3[1] ? -$signed({1'b0, mag_3}) : $signed({1'b0, mag_3});
  end

  always_ff @(posedge clk) begin
    sine <= res_3;
  end

endmodule

`default_nettype wire

/* hdl/tlsb_div.sv */
// tlsb_div: scales a magnitude by gamma in two partial products, then divides
// one quotient bit per cycle and saturates to q1.15; depends on tlsb_pkg
`default_nettype none

module tlsb_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tlsb_pkg::div_req_t req,
  output tlsb_pkg::div_rsp_t      rsp
);

  tlsb_pkg::div_state_t state, state_next;

  logic                              neg;
  logic [tlsb_pkg::MAG_W-1:0]        mag;
  logic [31:0]                       den;
  logic [15:0]                       gamma;
  logic [tlsb_pkg::DIV_NW-1:0]       acc;
  logic [31:0]                       rem;
  logic [tlsb_pkg::DIV_CW-1:0]       cnt;
  logic [32:0]                       prod;
  logic [32:0]                       trial;
  logic                              fits;
  logic signed [15:0]                quo;

  always_comb begin
    state_next = state;
    unique case (state)
      tlsb_pkg::DV_IDLE: if (req.start) state_next = tlsb_pkg::DV_MLO;
      tlsb_pkg::DV_MLO:  state_next = tlsb_pkg::DV_MHI;
      tlsb_pkg::DV_MHI:  state_next = tlsb_pkg::DV_RUN;
      tlsb_pkg::DV_RUN: begin
        if (cnt == tlsb_pkg::DIV_CW'(tlsb_pkg::DIV_NW - 1)) state_next = tlsb_pkg::DV_DONE;
      end
      tlsb_pkg::DV_DONE: state_next = tlsb_pkg::DV_IDLE;
      default:           state_next = tlsb_pkg::DV_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state == tlsb_pkg::DV_DONE);
    rsp.quo  = quo;
  end

  always_comb begin
    prod  = (state == tlsb_pkg::DV_MLO) ? 33'(gamma) * 33'(mag[16:0])
                                        : 33'(gamma) * 33'(mag[33:17]);
    trial = {rem, acc[tlsb_pkg::DIV_NW-1]};
    fits  = (trial >= {1'b0, den});
    if (neg) begin
      quo = (acc > tlsb_pkg::DIV_NW'(32768)) ? 16'sh8000 : -$signed(acc[15:0]);
    end else begin
      quo = (acc > tlsb_pkg::DIV_NW'(32767)) ? 16'sh7FFF : $signed(acc[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlsb_pkg::DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      tlsb_pkg::DV_IDLE: begin
        if (req.start) begin
          neg   <= req.neg;
          mag   <= req.mag;
          den   <= req.den;
          gamma <= req.gamma;
        end
      end
      tlsb_pkg::DV_MLO: begin
        acc <= tlsb_pkg::DIV_NW'(prod);
      end
      tlsb_pkg::DV_MHI: begin
        acc <= acc + {prod, 17'd0};
        rem <= '0;
        cnt <= '0;
      end
      tlsb_pkg::DV_RUN: begin
        rem <= fits ? 32'(trial - {1'b0, den}) : trial[31:0];
        acc <= {acc[tlsb_pkg::DIV_NW-2:0], fits};
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/turtle_lsystem_segment_builder.sv */
// turtle_lsystem_segment_builder: top level with sequencer, turtle state,
// branch stack and segment store; depends on tlsb_pkg, tlsb_ram, tlsb_sine, tlsb_div
//
// One item at a time. Turns, pushes and ignored characters go from dispatch to idle,
// pops add a stack load, move and draw characters wait on the 4-stage sine/cosine
// pipeline, end items go to the result state and output hand-off. A read hit sends
// each non-flat coordinate through the shared divider, one quotient bit per cycle
// over 50 bits. The next item is taken while a result waits in the output register.
// Branch stack and segment store are synchronous RAMs with no clearing pass; reads
// are bounded by the stack pointer and the segment count.
`default_nettype none

module turtle_lsystem_segment_builder #(
  parameter int unsigned STACK_DEPTH  = tlsb_pkg::STACK_DEPTH_DEF,
  parameter int unsigned MAX_SEGMENTS = tlsb_pkg::MAX_SEG_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic [7:0]         cmd_char,
  input  wire logic [11:0]        read_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [12:0]             seg_count,
  output logic [2:0]              error_flags,
  output logic                    read_ok,
  output logic signed [15:0]      start_x,
  output logic signed [15:0]      start_y,
  output logic signed [15:0]      end_x,
  output logic signed [15:0]      end_y,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);

  localparam int unsigned SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SA_W  = $clog2(STACK_DEPTH);
  localparam int unsigned SEG_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned MA_W  = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW    = (SEG_W > 13) ? SEG_W : 13;
  localparam int unsigned IXW   = (SEG_W > 12) ? SEG_W : 12;
  localparam int unsigned IAW   = (MA_W > 12) ? MA_W : 12;

  tlsb_pkg::tlsb_state_t state, state_next;

  logic [15:0] turn_step, start_heading, scale_gamma;
  logic [63:0] draw_chars;
  logic [3:0]  draw_char_count;

  logic [1:0]  req_q;
  logic [7:0]  ch_q;
  logic [11:0] idx_q;

  logic signed [31:0] pos_x, pos_y;
  logic [15:0]        heading;
  logic [SP_W-1:0]    sp;
  logic [SEG_W-1:0]   seg_total;
  logic signed [31:0] box_xmin, box_xmax, box_ymin, box_ymax;
  logic [2:0]         err_bits;
  logic               word_closed;
  logic [2:0]         cnt;
  logic               draw_q;
  logic [1:0]         ci;
  logic signed [15:0] coord [4];
  logic               res_read_ok;

  logic in_acc, new_word;
  logic d_plus, d_minus, d_move, d_push, d_pop, d_draw;
  logic push_ok, pop_ok, seg_full, rd_hit;
  logic [SP_W-1:0] sp_m1;
  logic [CW-1:0]   seg_total_ext;
  logic [IAW-1:0]  idx_ext;

  logic                stk_we, stk_re, seg_we, seg_re, out_load;
  logic [tlsb_pkg::STK_W-1:0]  stk_rdata;
  logic [tlsb_pkg::SEG_DW-1:0] seg_rdata;

  logic signed [15:0] sin_v, cos_v;
  logic signed [31:0] nx, ny;

  logic signed [31:0] op_p, op_lo, op_hi;
  logic signed [33:0] op_d;
  logic [32:0]        op_den;
  logic               flat;

  tlsb_pkg::div_req_t div_req;
  tlsb_pkg::div_rsp_t div_rsp;

  assign in_acc   = in_valid && !in_stall;
  assign new_word = in_acc && word_closed && ((req_type == tlsb_pkg::REQ_CMD) ||
                                              (req_type == tlsb_pkg::REQ_END));
  assign push_ok  = (sp < SP_W'(STACK_DEPTH));
  assign pop_ok   = (sp != '0);
  assign sp_m1    = sp - 1'b1;
  assign seg_full = (seg_total >= SEG_W'(MAX_SEGMENTS));
  assign rd_hit   = (IXW'(idx_q) < IXW'(seg_total));
  assign seg_total_ext = CW'(seg_total);
  assign idx_ext  = IAW'(idx_q);

  // character decode, specials take priority over draw characters
  always_comb begin
    d_plus  = 1'b0;
    d_minus = 1'b0;
    d_move  = 1'b0;
    d_push  = 1'b0;
    d_pop   = 1'b0;
    d_draw  = 1'b0;
    unique case (ch_q)
      tlsb_pkg::CH_PLUS:  d_plus  = 1'b1;
      tlsb_pkg::CH_MINUS: d_minus = 1'b1;
      tlsb_pkg::CH_MOVE:  d_move  = 1'b1;
      tlsb_pkg::CH_PUSH:  d_push  = 1'b1;
      tlsb_pkg::CH_POP:   d_pop   = 1'b1;
      tlsb_pkg::CH_LF, tlsb_pkg::CH_CR, tlsb_pkg::CH_SPACE: begin
      end
      default: d_draw = tlsb_pkg::is_draw(draw_chars, draw_char_count, ch_q);
    endcase
  end

  tlsb_sine u_sin (
    .clk   (clk),
    .angle (heading),
    .sine  (sin_v)
  );

  tlsb_sine u_cos (
    .clk   (clk),
    .angle (heading + tlsb_pkg::QUARTER),
    .sine  (cos_v)
  );

  assign nx = tlsb_pkg::sat_step(pos_x, cos_v);
  assign ny = tlsb_pkg::sat_step(pos_y, sin_v);

  tlsb_ram #(
    .WIDTH (tlsb_pkg::STK_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (sp[SA_W-1:0]),
    .wdata ({pos_x, pos_y, heading}),
    .re    (stk_re),
    .raddr (sp_m1[SA_W-1:0]),
    .rdata (stk_rdata)
  );

  tlsb_ram #(
    .WIDTH (tlsb_pkg::SEG_DW),
    .DEPTH (MAX_SEGMENTS)
  ) u_segs (
    .clk   (clk),
    .we    (seg_we),
    .waddr (seg_total[MA_W-1:0]),
    .wdata ({pos_x, pos_y, nx, ny}),
    .re    (seg_re),
    .raddr (idx_ext[MA_W-1:0]),
    .rdata (seg_rdata)
  );

  // operand select for the coordinate being normalized
  always_comb begin
    unique case (ci)
      2'd0: op_p = seg_rdata[127:96];
      2'd1: op_p = seg_rdata[95:64];
      2'd2: op_p = seg_rdata[63:32];
      2'd3: op_p = seg_rdata[31:0];
      default: op_p = '0;
    endcase
    op_lo  = ci[0] ? box_ymin : box_xmin;
    op_hi  = ci[0] ? box_ymax : box_xmax;
    op_d   = {op_p[31], op_p, 1'b0} - {{2{op_hi[31]}}, op_hi} - {{2{op_lo[31]}}, op_lo};
    op_den = {op_hi[31], op_hi} - {op_lo[31], op_lo};
    flat   = !(op_hi > op_lo);
  end

  always_comb begin
    div_req.start = (state == tlsb_pkg::ST_COORD) && !flat;
    div_req.neg   = op_d[33];
    div_req.mag   = op_d[33] ? 34'(-op_d) : 34'(op_d);
    div_req.den   = op_den[31:0];
    div_req.gamma = scale_gamma;
  end

  tlsb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tlsb_pkg::ST_IDLE: begin
        if (in_acc && (req_type != tlsb_pkg::REQ_NONE)) state_next = tlsb_pkg::ST_DISPATCH;
      end
      tlsb_pkg::ST_DISPATCH: begin
        unique case (req_q)
          tlsb_pkg::REQ_CMD: begin
            if (d_move || (d_draw && !seg_full)) begin
              state_next = tlsb_pkg::ST_STEP;
            end else if (d_pop && pop_ok) begin
              state_next = tlsb_pkg::ST_POP_LOAD;
            end else begin
              state_next = tlsb_pkg::ST_IDLE;
            end
          end
          tlsb_pkg::REQ_END:  state_next = tlsb_pkg::ST_RESULT;
          tlsb_pkg::REQ_READ: state_next = rd_hit ? tlsb_pkg::ST_SEG_RD : tlsb_pkg::ST_RESULT;
          default:            state_next = tlsb_pkg::ST_IDLE;
        endcase
      end
      tlsb_pkg::ST_STEP: begin
        if (cnt == tlsb_pkg::SINE_LAT) state_next = tlsb_pkg::ST_IDLE;
      end
      tlsb_pkg::ST_POP_LOAD: state_next = tlsb_pkg::ST_IDLE;
      tlsb_pkg::ST_SEG_RD:   state_next = tlsb_pkg::ST_COORD;
      tlsb_pkg::ST_COORD: begin
        if (!flat) begin
          state_next = tlsb_pkg::ST_DIV_WAIT;
        end else if (ci == 2'd3) begin
          state_next = tlsb_pkg::ST_RESULT;
        end
      end
      tlsb_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = (ci == 2'd3) ? tlsb_pkg::ST_RESULT : tlsb_pkg::ST_COORD;
        end
      end
      tlsb_pkg::ST_RESULT: begin
        if (!out_valid || !out_stall) state_next = tlsb_pkg::ST_IDLE;
      end
      default: state_next = tlsb_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = (state != tlsb_pkg::ST_IDLE);
    stk_we   = (state == tlsb_pkg::ST_DISPATCH) && (req_q == tlsb_pkg::REQ_CMD) &&
               d_push && push_ok;
    stk_re   = (state == tlsb_pkg::ST_DISPATCH) && (req_q == tlsb_pkg::REQ_CMD) &&
               d_pop && pop_ok;
    seg_re   = (state == tlsb_pkg::ST_DISPATCH) && (req_q == tlsb_pkg::REQ_READ) && rd_hit;
    seg_we   = (state == tlsb_pkg::ST_STEP) && (cnt == tlsb_pkg::SINE_LAT) && draw_q;
    out_load = (state == tlsb_pkg::ST_RESULT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlsb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_step       <= tlsb_pkg::TURN_STEP_RST;
      start_heading   <= tlsb_pkg::START_HEAD_RST;
      scale_gamma     <= tlsb_pkg::GAMMA_RST;
      draw_chars      <= tlsb_pkg::DRAW_CHARS_RST;
      draw_char_count <= tlsb_pkg::DRAW_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tlsb_pkg::REG_TURN_STEP:  turn_step       <= cfg_data[15:0];
        tlsb_pkg::REG_START_HEAD: start_heading   <= cfg_data[15:0];
        tlsb_pkg::REG_GAMMA:      scale_gamma     <= cfg_data[15:0];
        tlsb_pkg::REG_DRAW_CHARS: draw_chars      <= cfg_data;
        tlsb_pkg::REG_DRAW_COUNT: draw_char_count <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // item payload and coordinate results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_q <= req_type;
      ch_q  <= cmd_char;
      idx_q <= read_index;
    end
    if (state == tlsb_pkg::ST_DISPATCH) begin
      cnt    <= '0;
      draw_q <= d_draw;
      ci     <= '0;
      for (int i = 0; i < 4; i++) coord[i] <= '0;
      res_read_ok <= (req_q == tlsb_pkg::REQ_READ) && rd_hit;
    end else if (state == tlsb_pkg::ST_STEP) begin
      cnt <= cnt + 1'b1;
    end else if ((state == tlsb_pkg::ST_COORD) && flat) begin
      coord[ci] <= '0;
      ci        <= ci + 1'b1;
    end else if ((state == tlsb_pkg::ST_DIV_WAIT) && div_rsp.done) begin
      coord[ci] <= div_rsp.quo;
      ci        <= ci + 1'b1;
    end
  end

  // turtle and word state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x       <= '0;
      pos_y       <= '0;
      heading     <= tlsb_pkg::START_HEAD_RST;
      sp          <= '0;
      seg_total   <= '0;
      box_xmin    <= '0;
      box_xmax    <= '0;
      box_ymin    <= '0;
      box_ymax    <= '0;
      err_bits    <= '0;
      word_closed <= 1'b1;
    end else if (new_word) begin
      pos_x       <= '0;
      pos_y       <= '0;
      heading     <= start_heading;
      sp          <= '0;
      seg_total   <= '0;
      box_xmin    <= '0;
      box_xmax    <= '0;
      box_ymin    <= '0;
      box_ymax    <= '0;
      err_bits    <= '0;
      word_closed <= 1'b0;
    end else begin
      unique case (state)
        tlsb_pkg::ST_DISPATCH: begin
          if (req_q == tlsb_pkg::REQ_END) begin
            word_closed <= 1'b1;
          end else if (req_q == tlsb_pkg::REQ_CMD) begin
            if (d_plus) heading <= heading + turn_step;
            if (d_minus) heading <= heading - turn_step;
            if (d_push) begin
              if (push_ok) sp <= sp + 1'b1;
              else err_bits[tlsb_pkg::ERR_OVERFLOW] <= 1'b1;
            end
            if (d_pop) begin
              if (pop_ok) sp <= sp_m1;
              else err_bits[tlsb_pkg::ERR_UNDERFLOW] <= 1'b1;
            end
            if (d_draw && seg_full) err_bits[tlsb_pkg::ERR_FULL] <= 1'b1;
          end
        end
        tlsb_pkg::ST_STEP: begin
          if (cnt == tlsb_pkg::SINE_LAT) begin
            pos_x <= nx;
            pos_y <= ny;
            if (draw_q) begin
              seg_total <= seg_total + 1'b1;
              if (nx < box_xmin) box_xmin <= nx;
              if (nx > box_xmax) box_xmax <= nx;
              if (ny < box_ymin) box_ymin <= ny;
              if (ny > box_ymax) box_ymax <= ny;
            end
          end
        end
        tlsb_pkg::ST_POP_LOAD: begin
          pos_x   <= stk_rdata[79:48];
          pos_y   <= stk_rdata[47:16];
          heading <= stk_rdata[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      seg_count   <= seg_total_ext[12:0];
      error_flags <= err_bits;
      read_ok     <= res_read_ok;
      start_x     <= coord[0];
      start_y     <= coord[1];
      end_x       <= coord[2];
      end_y       <= coord[3];
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_seg_bound: assert property (@(posedge clk) disable iff (rst)
    seg_total <= SEG_W'(MAX_SEGMENTS))
    else $error("segment count beyond store size");

  a_box_origin: assert property (@(posedge clk) disable iff (rst)
    (box_xmin <= 0) && (box_xmax >= 0) && (box_ymin <= 0) && (box_ymax >= 0))
    else $error("bounding box lost the origin");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !read_ok |-> (start_x == 0) && (start_y == 0) && (end_x == 0) && (end_y == 0))
    else $error("coordinates set without a segment hit");

endmodule

`default_nettype wire

/* verif/tlsb_turtle_checker.sv */
// tlsb_turtle_checker: watches the request, result and register channels of the
// turtle l-system segment builder, predicts each result and compares it field by field
// depends on tlsb_pkg
`default_nettype none

module tlsb_turtle_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic [7:0]         cmd_char,
  input  wire logic [11:0]        read_index,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [12:0]        seg_count,
  input  wire logic [2:0]         error_flags,
  input  wire logic               read_ok,
  input  wire logic signed [15:0] start_x,
  input  wire logic signed [15:0] start_y,
  input  wire logic signed [15:0] end_x,
  input  wire logic signed [15:0] end_y,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  output int                      errors,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [12:0]        cnt;
    logic [2:0]         err;
    logic               ok;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
  } seg_reply_t;

  seg_reply_t  replies_due[$];

  logic [15:0] turn_step, start_head, gamma;
  logic [63:0] chars;
  logic [3:0]  nchars;

  int          pos_x, pos_y;
  logic [15:0] heading;
  int          stk_x[tlsb_pkg::STACK_DEPTH_DEF];
  int          stk_y[tlsb_pkg::STACK_DEPTH_DEF];
  logic [15:0] stk_h[tlsb_pkg::STACK_DEPTH_DEF];
  int          stk_n;
  int          seg_sx[tlsb_pkg::MAX_SEG_DEF];
  int          seg_sy[tlsb_pkg::MAX_SEG_DEF];
  int          seg_ex[tlsb_pkg::MAX_SEG_DEF];
  int          seg_ey[tlsb_pkg::MAX_SEG_DEF];
  int          seg_n;
  int          box[4];
  logic [2:0]  err;
  bit          closed;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic int turtle_sine(input logic [15:0] h);
    logic [1:0]  q;
    logic [31:0] z, z2, t, s;
    int          v;
    q = h[15:14];
    z = {18'b0, h[13:0]};
    if (q[0]) z = 32'd16384 - z;
    z2 = (z * z) >> 14;
    t  = ((32'd21024 - ((32'd2320 * z2) >> 14)) * z2) >> 14;
    t  = 32'd51472 - t;
    s  = (t * z) >> 14;
    if (s > 32'd32767) s = 32'd32767;
    v = int'(s);
    return q[1] ? -v : v;
  endfunction

  function automatic int clamp_add(input int p, input int v);
    longint sum;
    sum = longint'(p) + 2 * longint'(v);
    if (sum > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (sum < -64'sd2147483648) return 32'sh8000_0000;
    return int'(sum);
  endfunction

  function automatic logic signed [15:0] unit_coord(input int p, input int lo, input int hi);
    longint num, q, g;
    if (hi == 0 && lo == 0) return '0;
    if (hi <= lo) return '0;
    g   = longint'({48'b0, gamma});
    num = g * (2 * longint'(p) - longint'(hi) - longint'(lo));
    q   = num / (longint'(hi) - longint'(lo));
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic bit draw_hit(input logic [7:0] ch);
    int n;
    n = (nchars > 4'd8) ? 8 : int'(nchars);
    for (int i = 0; i < n; i++) begin
      if (chars[8*i +: 8] == ch) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic move_unit();
    int c, s;
    c = turtle_sine(heading + tlsb_pkg::QUARTER);
    s = turtle_sine(heading);
    pos_x = clamp_add(pos_x, c);
    pos_y = clamp_add(pos_y, s);
  endtask

  task automatic open_word();
    pos_x   = 0;
    pos_y   = 0;
    heading = start_head;
    stk_n   = 0;
    seg_n   = 0;
    box     = '{0, 0, 0, 0};
    err     = '0;
    closed  = 1'b0;
  endtask

  task automatic take_char(input logic [7:0] ch);
    case (ch)
      tlsb_pkg::CH_LF, tlsb_pkg::CH_CR, tlsb_pkg::CH_SPACE: ;
      tlsb_pkg::CH_PLUS:  heading = heading + turn_step;
      tlsb_pkg::CH_MINUS: heading = heading - turn_step;
      tlsb_pkg::CH_MOVE:  move_unit();
      tlsb_pkg::CH_PUSH: begin
        if (stk_n >= tlsb_pkg::STACK_DEPTH_DEF) begin
          err[tlsb_pkg::ERR_OVERFLOW] = 1'b1;
        end else begin
          stk_x[stk_n] = pos_x;
          stk_y[stk_n] = pos_y;
          stk_h[stk_n] = heading;
          stk_n++;
        end
      end
      tlsb_pkg::CH_POP: begin
        if (stk_n == 0) begin
          err[tlsb_pkg::ERR_UNDERFLOW] = 1'b1;
        end else begin
          stk_n--;
          pos_x   = stk_x[stk_n];
          pos_y   = stk_y[stk_n];
          heading = stk_h[stk_n];
        end
      end
      default: begin
        if (draw_hit(ch)) begin
          if (seg_n >= tlsb_pkg::MAX_SEG_DEF) begin
            err[tlsb_pkg::ERR_FULL] = 1'b1;
          end else begin
            seg_sx[seg_n] = pos_x;
            seg_sy[seg_n] = pos_y;
            move_unit();
            seg_ex[seg_n] = pos_x;
            seg_ey[seg_n] = pos_y;
            seg_n++;
            if (pos_x < box[0]) box[0] = pos_x;
            if (pos_x > box[1]) box[1] = pos_x;
            if (pos_y < box[2]) box[2] = pos_y;
            if (pos_y > box[3]) box[3] = pos_y;
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    seg_reply_t r;
    seg_reply_t want;
    if (rst) begin
      turn_step  = tlsb_pkg::TURN_STEP_RST;
      start_head = tlsb_pkg::START_HEAD_RST;
      gamma      = tlsb_pkg::GAMMA_RST;
      chars      = tlsb_pkg::DRAW_CHARS_RST;
      nchars     = tlsb_pkg::DRAW_COUNT_RST;
      open_word();
      closed = 1'b1;
      replies_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tlsb_pkg::REG_TURN_STEP:  turn_step  = cfg_data[15:0];
          tlsb_pkg::REG_START_HEAD: start_head = cfg_data[15:0];
          tlsb_pkg::REG_GAMMA:      gamma      = cfg_data[15:0];
          tlsb_pkg::REG_DRAW_CHARS: chars      = cfg_data;
          tlsb_pkg::REG_DRAW_COUNT: nchars     = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (req_type)
          tlsb_pkg::REQ_CMD: begin
            if (closed) open_word();
            take_char(cmd_char);
          end
          tlsb_pkg::REQ_END, tlsb_pkg::REQ_READ: begin
            r = '{default: '0};
            if (req_type == tlsb_pkg::REQ_END) begin
              if (closed) open_word();
              closed = 1'b1;
            end else if (int'(read_index) < seg_n) begin
              r.ok = 1'b1;
              r.sx = unit_coord(seg_sx[read_index], box[0], box[1]);
              r.sy = unit_coord(seg_sy[read_index], box[2], box[3]);
              r.ex = unit_coord(seg_ex[read_index], box[0], box[1]);
              r.ey = unit_coord(seg_ey[read_index], box[2], box[3]);
            end
            r.cnt = seg_n[12:0];
            r.err = err;
            replies_due = {replies_due, r};
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result with none expected, count %0d", $time, seg_count);
          errors++;
        end else begin
          want = replies_due.pop_front();
          check_field("seg_count", want.cnt, seg_count);
          check_field("error_flags", want.err, error_flags);
          check_field("read_ok", want.ok, read_ok);
          check_field("start_x", want.sx, start_x);
          check_field("start_y", want.sy, start_y);
          check_field("end_x", want.ex, end_x);
          check_field("end_y", want.ey, end_y);
        end
      end
    end
    pending = replies_due.size();
  end

endmodule

`default_nettype wire

/* verif/turtle_lsystem_segment_builder_test.sv */
// turtle_lsystem_segment_builder_test: drives words, end and read items and register
// settings into the builder; depends on tlsb_pkg, the builder and tlsb_turtle_checker
`default_nettype none

module turtle_lsystem_segment_builder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES  = 3000;
  localparam int WATCH_LIMIT  = 20000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         req_type = tlsb_pkg::REQ_NONE;
  logic [7:0]         cmd_char = '0;
  logic [11:0]        read_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [12:0]        seg_count;
  logic [2:0]         error_flags;
  logic               read_ok;
  logic signed [15:0] start_x, start_y, end_x, end_y;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;

  int          errors, pending;
  bit          idle_on = 1'b1;
  bit          hold_now = 1'b0;
  int          quiet_cycles = 0;
  logic [63:0] cur_chars = tlsb_pkg::DRAW_CHARS_RST;
  logic [3:0]  cur_n = tlsb_pkg::DRAW_COUNT_RST;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  turtle_lsystem_segment_builder i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .cmd_char(cmd_char), .read_index(read_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .seg_count(seg_count), .error_flags(error_flags), .read_ok(read_ok),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tlsb_turtle_checker i_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .cmd_char(cmd_char), .read_index(read_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .seg_count(seg_count), .error_flags(error_flags), .read_ok(read_ok),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side stalls
  initial begin
    int len;
    @(posedge clk);
    forever begin
      if (hold_now) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_now = 1'b0;
      end else begin
        len = pick_gap();
        out_stall <= (len > 0);
        repeat ((len > 0) ? len : $urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(input logic [1:0] req, input logic [7:0] ch, input logic [11:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    cmd_char   <= ch;
    read_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic put_char(input logic [7:0] ch);
    send(tlsb_pkg::REQ_CMD, ch, 12'($urandom));
  endtask

  task automatic put_read(input logic [11:0] idx);
    send(tlsb_pkg::REQ_READ, 8'($urandom), idx);
  endtask

  task automatic put_end();
    send(tlsb_pkg::REQ_END, 8'($urandom), 12'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] turn, input logic [15:0] head,
                          input logic [15:0] gam, input logic [63:0] chs,
                          input logic [3:0] n);
    logic [63:0] vals[5];
    vals = '{{48'b0, turn}, {48'b0, head}, {48'b0, gam}, chs, {60'b0, n}};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    cur_chars = chs;
    cur_n     = n;
  endtask

  function automatic logic [7:0] pick_char(input int depth, output bit is_seg);
    int r, n;
    logic [7:0] ws[3];
    ws = '{tlsb_pkg::CH_LF, tlsb_pkg::CH_CR, tlsb_pkg::CH_SPACE};
    is_seg = 1'b0;
    n = (cur_n > 4'd8) ? 8 : int'(cur_n);
    r = $urandom_range(0, 99);
    if (r < 35 && n > 0) begin
      is_seg = 1'b1;
      return cur_chars[8*$urandom_range(0, n-1) +: 8];
    end
    if (r < 45) return tlsb_pkg::CH_PLUS;
    if (r < 55) return tlsb_pkg::CH_MINUS;
    if (r < 63) return tlsb_pkg::CH_MOVE;
    if (r < 73) return (depth < 6) ? tlsb_pkg::CH_PUSH : tlsb_pkg::CH_PLUS;
    if (r < 83) return (depth > 0 || r == 82) ? tlsb_pkg::CH_POP : tlsb_pkg::CH_MINUS;
    if (r < 88) return ws[$urandom_range(0, 2)];
    return 8'($urandom);
  endfunction

  task automatic run_words(input int n_items);
    int sent, len, depth, segs;
    bit seg;
    logic [7:0] ch;
    sent = 0;
    while (sent < n_items) begin
      len   = $urandom_range(1, 30);
      depth = 0;
      segs  = 0;
      for (int i = 0; i < len; i++) begin
        ch = pick_char(depth, seg);
        if (seg) segs++;
        if (ch == tlsb_pkg::CH_PUSH) depth++;
        if (ch == tlsb_pkg::CH_POP && depth > 0) depth--;
        put_char(ch);
        sent++;
        if ($urandom_range(0, 24) == 0) begin
          put_read(12'($urandom_range(0, segs)));
          sent++;
        end
      end
      if ($urandom_range(0, 9) != 0) begin
        put_end();
        sent++;
      end
      for (int k = $urandom_range(0, 2); k > 0; k--) begin
        if ($urandom_range(0, 7) == 0) put_read(12'($urandom));
        else put_read(12'($urandom_range(0, segs + 1)));
        sent++;
      end
      if ($urandom_range(0, 29) == 0) begin
        send(tlsb_pkg::REQ_NONE, 8'($urandom), 12'($urandom));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults, one draw character
    put_end();
    put_read(12'd0);
    put_char(8'h46);
    put_char(tlsb_pkg::CH_PLUS);
    put_char(8'h46);
    put_char(tlsb_pkg::CH_MINUS);
    put_char(tlsb_pkg::CH_MOVE);
    put_char(tlsb_pkg::CH_PUSH);
    put_char(8'h46);
    put_char(tlsb_pkg::CH_POP);
    put_char(tlsb_pkg::CH_POP);
    put_char(tlsb_pkg::CH_SPACE);
    put_char(tlsb_pkg::CH_LF);
    put_char(tlsb_pkg::CH_CR);
    put_char(8'hFF);
    put_char(8'h00);
    send(tlsb_pkg::REQ_NONE, 8'h46, 12'hFFF);
    put_read(12'd1);
    put_char(8'h46);
    put_end();
    put_read(12'd0);
    put_read(12'd3);
    put_read(12'd4095);
    put_read(12'd2);
    // stack overflow
    for (int i = 0; i < 33; i++) put_char(tlsb_pkg::CH_PUSH);
    put_char(8'h46);
    put_end();
    put_read(12'd0);
    run_words(150);
    drain();

    set_regs(16'hFFFF, 16'h0000, 16'd32768, 64'h4241_5A59_5847_4146, 4'd8);
    hold_now = 1'b1;
    run_words(180);
    drain();

    set_regs(16'h0000, 16'hFFFF, 16'h0000, 64'($urandom) << 32 | 64'($urandom), 4'd0);
    run_words(60);
    drain();

    set_regs(16'($urandom), 16'($urandom), 16'hFFFF,
             {32'($urandom), 32'($urandom) | 32'h46}, 4'd15);
    run_words(150);
    drain();

    set_regs(16'd8192, 16'd16384, 16'd29491, 64'h59_5846, 4'd3);
    run_words(150);
    drain();

    // back to back, no idling
    idle_on = 1'b0;
    set_regs(16'd16384, 16'd100, 16'd29491, 64'h46, 4'd1);
    run_words(100);
    idle_on = 1'b1;
    drain();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* turtle_lsystem_segment_builder.f */
hdl/tlsb_pkg.sv
hdl/tlsb_ram.sv
hdl/tlsb_sine.sv
hdl/tlsb_div.sv
hdl/turtle_lsystem_segment_builder.sv
verif/tlsb_turtle_checker.sv
verif/turtle_lsystem_segment_builder_test.sv
